/* sv/cmr_pkg.sv */
// Shared types, status codes and character helpers for the chunked message reassembler.
package cmr_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 4096;
    localparam int unsigned HEADER_BYTES     = 5;
    localparam int unsigned PREFIX_LEN       = 10;
    localparam int unsigned CNT_W            = 17;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_COMPLETE = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic        end_of_write;
        logic [11:0] read_index;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic [11:0] source_length;
        logic [11:0] destination_length;
        logic [12:0] payload_offset;
        logic [11:0] payload_length;
        logic [7:0]  message_tag;
    } t_result;

    typedef struct packed {
        logic take_wr;
        logic take_rd;
        logic clr;
        logic scan;
        logic scan_end;
        logic sel_read;
    } t_cmd;

    typedef struct packed {
        logic acc_clear;
        logic acc_scan;
        logic need_clear;
        logic clr_last;
        logic pend_last;
        logic pend_scan;
        logic scan_done;
    } t_sts;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = 8'h69;
            4'd1: c = 8'h6E;
            4'd2: c = 8'h74;
            4'd3: c = 8'h65;
            4'd4: c = 8'h72;
            4'd5: c = 8'h66;
            4'd6: c = 8'h61;
            4'd7: c = 8'h63;
            4'd8: c = 8'h65;
            4'd9: c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

/* sv/cmr_ctrl.sv */
// Controller state machine sequencing beats, clear sweeps, scans and results.
module cmr_ctrl
    import cmr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CLEAR = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op) begin
                        o_cmd.take_rd = 1'b1;
                        n_state = S_READ;
                    end else begin
                        o_cmd.take_wr = 1'b1;
                        if (i_sts.acc_clear) begin
                            n_state = S_CLEAR;
                        end else if (i_sts.acc_scan) begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.sel_read = 1'b1;
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    if (!i_sts.pend_last) begin
                        n_state = S_IDLE;
                    end else if (i_sts.pend_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_end = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_EMIT: begin
                n_state = i_sts.need_clear ? S_CLEAR : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_IDLE && i_start && !i_op && !i_sts.acc_clear &&
            i_sts.pend_last && !i_sts.acc_scan) begin
            n_state = S_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_READ) || (r_state == S_EMIT);

endmodule

/* sv/cmr_datapath.sv */
// Datapath: message buffer, header and count registers, clear sweep and message scan.
module cmr_datapath
    import cmr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output t_result o_result
);

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUFFER_BYTES);
    localparam logic [CW-1:0]    BUF_C   = CW'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] r_q;

    logic [7:0]       r_tag, n_tag;
    logic             r_tag_v, n_tag_v;
    logic [CNT_W-1:0] r_recv, n_recv;
    logic [CW-1:0]    r_exp, n_exp;
    logic [CNT_W-1:0] r_wp, n_wp;
    logic [31:0]      r_hdr, n_hdr;
    logic             r_skip, n_skip;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_chi, n_chi;
    logic             r_pend_last, r_pend_scan;
    t_result          r_res;
    logic [2:0]       n_status;
    logic             n_scan;
    logic             r_rd_oob;

    logic [CW-1:0]    r_sa, r_sp, r_start, r_sl, r_dl;
    logic             r_sv, r_seg_ok, r_pfx_ok, r_ok;
    logic [1:0]       r_part;

    logic [7:0]       b;
    logic [CNT_W-1:0] h_size;
    logic             tag_chg;
    logic [17:0]      addr;
    logic             chunk_we;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [7:0]       mem_wd;

    logic [CW-1:0]    seglen;
    logic             is_nl;

    always_comb begin
        b        = i_item.data_byte;
        n_tag    = r_tag;
        n_tag_v  = r_tag_v;
        n_recv   = r_recv;
        n_exp    = r_exp;
        n_wp     = r_wp;
        n_hdr    = r_hdr;
        n_skip   = r_skip;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_chi    = r_chi;
        n_status = ST_ACCEPTED;
        n_scan   = 1'b0;
        chunk_we = 1'b0;
        h_size   = CNT_W'({b, r_hdr[31:24]}) + CNT_W'(1);
        tag_chg  = !r_tag_v || (r_tag != r_hdr[7:0]);
        addr     = 18'(r_hdr[23:8]) + 18'(r_wp - HDR_CNT);
        if (!r_skip) begin
            if (r_wp < HDR_CNT - CNT_W'(1)) begin
                n_hdr[8*r_wp[1:0] +: 8] = b;
            end else if (r_wp == HDR_CNT - CNT_W'(1)) begin
                if (tag_chg) begin
                    n_tag   = r_hdr[7:0];
                    n_tag_v = 1'b1;
                    n_lo    = '0;
                    n_chi   = r_hi;
                    n_hi    = '0;
                    n_recv  = '0;
                    n_exp   = '0;
                end
                if (h_size > BUF_CNT) begin
                    n_tag_v = 1'b0;
                    n_lo    = '0;
                    n_chi   = r_hi;
                    n_hi    = '0;
                    n_recv  = '0;
                    n_exp   = '0;
                    n_skip  = 1'b1;
                end else if (n_exp != CW'(h_size)) begin
                    if (CW'(h_size) < n_hi) begin
                        n_lo  = CW'(h_size);
                        n_chi = n_hi;
                        n_hi  = CW'(h_size);
                    end
                    n_exp = CW'(h_size);
                end
            end else begin
                if (addr >= 18'(r_exp)) begin
                    n_tag_v = 1'b0;
                    n_lo    = '0;
                    n_chi   = r_hi;
                    n_hi    = '0;
                    n_recv  = '0;
                    n_exp   = '0;
                    n_skip  = 1'b1;
                end else begin
                    chunk_we = 1'b1;
                    if (CW'(addr) + CW'(1) > r_hi) begin
                        n_hi = CW'(addr) + CW'(1);
                    end
                    if (r_recv != CNT_MAX) begin
                        n_recv = r_recv + CNT_W'(1);
                    end
                end
            end
        end
        if (r_wp != CNT_MAX) begin
            n_wp = r_wp + CNT_W'(1);
        end
        if (n_skip) begin
            n_status = ST_RANGE;
        end else if (i_item.end_of_write && n_wp < HDR_CNT) begin
            n_status = ST_SHORT;
            n_tag_v  = 1'b0;
            n_lo     = '0;
            n_chi    = r_hi;
            n_hi     = '0;
            n_recv   = '0;
            n_exp    = '0;
        end else if (n_recv >= CNT_W'(n_exp)) begin
            n_scan = 1'b1;
        end
    end

    always_comb begin
        seglen = r_sp - r_start;
        is_nl  = (r_q == CH_NEWLINE);
    end

    always_comb begin
        mem_we = i_cmd.clr || (i_cmd.take_wr && chunk_we);
        mem_wa = i_cmd.clr ? AW'(r_lo) : AW'(addr);
        mem_wd = i_cmd.clr ? 8'h00 : b;
        mem_re = i_cmd.take_rd || (i_cmd.scan && r_sa != r_exp);
        mem_ra = i_cmd.take_rd ? AW'(i_item.read_index) : AW'(r_sa);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= '0;
            r_tag_v     <= 1'b0;
            r_recv      <= '0;
            r_exp       <= '0;
            r_wp        <= '0;
            r_hdr       <= '0;
            r_skip      <= 1'b0;
            r_hi        <= '0;
            r_lo        <= '0;
            r_chi       <= BUF_C;
            r_pend_last <= 1'b0;
            r_pend_scan <= 1'b0;
            r_sv        <= 1'b0;
            r_sa        <= '0;
        end else begin
            if (i_cmd.take_wr) begin
                r_tag   <= n_tag;
                r_tag_v <= n_tag_v;
                r_recv  <= n_recv;
                r_exp   <= n_exp;
                r_hi    <= n_hi;
                r_lo    <= n_lo;
                r_chi   <= n_chi;
                if (i_item.end_of_write) begin
                    r_wp        <= '0;
                    r_hdr       <= '0;
                    r_skip      <= 1'b0;
                    r_pend_last <= 1'b1;
                    r_pend_scan <= n_scan;
                    r_res       <= '{status: n_status, default: '0};
                    r_sa        <= '0;
                    r_sv        <= 1'b0;
                    r_part      <= '0;
                    r_start     <= '0;
                    r_seg_ok    <= 1'b1;
                    r_pfx_ok    <= 1'b1;
                    r_ok        <= 1'b1;
                    r_sl        <= '0;
                    r_dl        <= '0;
                end else begin
                    r_wp        <= n_wp;
                    r_hdr       <= n_hdr;
                    r_skip      <= n_skip;
                    r_pend_last <= 1'b0;
                end
            end
            if (i_cmd.take_rd) begin
                r_rd_oob <= (CNT_W'(i_item.read_index) >= BUF_CNT);
            end
            if (i_cmd.clr) begin
                r_lo <= r_lo + CW'(1);
            end
            if (i_cmd.scan) begin
                if (r_sa != r_exp) begin
                    r_sa <= r_sa + CW'(1);
                    r_sp <= r_sa;
                    r_sv <= 1'b1;
                end else begin
                    r_sv <= 1'b0;
                end
            end
            if (r_sv && r_part != 2'd2) begin
                if (is_nl) begin
                    if (r_part == 2'd0) begin
                        r_ok <= r_ok && r_seg_ok;
                        r_sl <= seglen;
                    end else begin
                        r_ok <= r_ok && r_seg_ok &&
                                !(seglen >= CW'(PREFIX_LEN) && r_pfx_ok);
                        r_dl <= seglen;
                    end
                    r_part   <= r_part + 2'd1;
                    r_start  <= r_sp + CW'(1);
                    r_seg_ok <= 1'b1;
                    r_pfx_ok <= 1'b1;
                end else begin
                    if (r_part == 2'd0) begin
                        r_seg_ok <= r_seg_ok && (is_alnum(r_q) || r_q == CH_DOT);
                    end else begin
                        r_seg_ok <= r_seg_ok && is_alnum(r_q);
                        if (seglen < CW'(PREFIX_LEN)) begin
                            r_pfx_ok <= r_pfx_ok && (r_q == prefix_char(4'(seglen)));
                        end
                    end
                end
            end
            if (i_cmd.scan_end) begin
                r_res.message_tag <= r_tag;
                if (r_ok && r_part == 2'd2) begin
                    r_res.status             <= ST_COMPLETE;
                    r_res.source_length      <= 12'(r_sl);
                    r_res.destination_length <= 12'(r_dl);
                    r_res.payload_offset     <= 13'(r_start);
                    r_res.payload_length     <= 12'(r_exp - r_start);
                end else begin
                    r_res.status <= ST_INVALID;
                end
                r_tag_v     <= 1'b0;
                r_recv      <= '0;
                r_exp       <= '0;
                r_hi        <= '0;
                r_lo        <= '0;
                r_chi       <= r_hi;
                r_pend_last <= 1'b0;
                r_pend_scan <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.acc_clear  = (n_lo < n_chi);
        o_sts.acc_scan   = i_item.end_of_write && n_scan;
        o_sts.need_clear = (r_lo < r_chi);
        o_sts.clr_last   = (r_lo + CW'(1) >= r_chi);
        o_sts.pend_last  = i_cmd.take_wr ? i_item.end_of_write : r_pend_last;
        o_sts.pend_scan  = r_pend_scan;
        o_sts.scan_done  = (r_sa == r_exp) && !r_sv;
        if (i_cmd.sel_read) begin
            o_result           = '0;
            o_result.status    = ST_READ;
            o_result.read_byte = r_rd_oob ? 8'h00 : r_q;
        end else begin
            o_result = r_res;
        end
    end

endmodule

/* sv/chunked_message_reassembler_core.sv */
// Top level of the chunked message reassembler: controller plus datapath.
//
// Usage: present an item on i_item and raise start; it is taken at an edge where
// busy is low. A write beat (operation 0) carries one byte of a received write,
// end_of_write marking the last byte. A read beat (operation 1) returns one
// buffered byte. Results appear on o_result for exactly one cycle with o_valid
// high; the receiver cannot stall them.
// A write beat that is not the last byte of a write gives no result; a read gives
// its result in the cycle after acceptance. The last beat of a write reports after
// any pending clear sweep and, for a completed message, its scan.
// Discarding a message or shrinking its size sweeps the dirty part of the buffer
// at one entry per cycle (up to the highest byte written). A completed message is
// scanned at one byte per cycle from the single memory read port, then its buffer is
// swept before busy drops. After reset the whole buffer is swept with busy high.
module chunked_message_reassembler_core
    import cmr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    t_cmd cmd;
    t_sts sts;

    cmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.operation),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    cmr_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
